@@ rtl/vlsf_pkg.sv @@
// ----------------------------------------------------------------------------
// vlsf_pkg: shared types and constants for the line scan frame buffer
// Request and result payloads, command codes, register indexes and the frame
// buffer write and read requests that pass between the top level and the buffer memory.
// ----------------------------------------------------------------------------
package vlsf_pkg;

  // Command codes of an input request.
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_REWIND = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BLANK_LINES = 2'd0,
    REG_FRAME_LINES = 2'd1,
    REG_LINE_REPEAT = 2'd2
  } reg_idx_t;

  localparam int CFG_W     = 9;
  localparam int LINE_W    = 9;
  localparam int ROW_IDX_W = 5;
  localparam int REP_W     = 4;
  localparam int PTR_W     = 6;
  localparam int FB_ADDR_W = 4;
  localparam int ROW_BITS  = 32;
  localparam int LANES     = ROW_BITS / 8;

  // Lines at which the sync width changes.
  localparam logic [LINE_W-1:0] SYNC_LONG_LINE  = 9'd1;
  localparam logic [LINE_W-1:0] SYNC_SHORT_LINE = 9'd7;

  // Register reset values.
  localparam logic [7:0]        BLANK_RESET  = 8'd32;
  localparam logic [LINE_W-1:0] FRAME_RESET  = 9'd262;
  localparam logic [REP_W-1:0]  REPEAT_RESET = 4'd12;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic                long_sync;
    logic                active_line;
    logic [ROW_BITS-1:0] pixels;
    logic                frame_done;
  } out_t;

  // One byte lane write into the frame buffer.
  typedef struct packed {
    logic                 en;
    logic [FB_ADDR_W-1:0] word;
    logic [1:0]           lane;
    logic [7:0]           data;
  } fb_wr_t;

  // One row read from the frame buffer.
  typedef struct packed {
    logic                 en;
    logic [FB_ADDR_W-1:0] word;
  } fb_rd_t;

endpackage

@@ rtl/video_line_scan_framebuffer.sv @@
// ----------------------------------------------------------------------------
// video_line_scan_framebuffer: line timing generator with a row frame buffer
// Steps line timing on each tick and stores received bytes for display.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry requests: a line tick, a received byte
//   or a receive timeout. Only a tick produces a result on out_valid/
//   out_stall/out_data, describing the sync width, whether a buffer row is
//   shown with its pixels, and whether the frame ended.
//   One request is taken every cycle while in_stall is low. A tick result
//   passes through the registered read of the frame buffer row, loaded when
//   its request is accepted, and then the output register, loaded once that
//   register is free of a held result.
//   Byte writes go into the buffer at acceptance, so a tick that follows
//   in the next cycle already sees the byte.
//   When the receiver stalls, the output register holds its result and one
//   more tick can finish its buffer read behind it; only when both are
//   full is in_stall raised.
//   Reset clears the counters, the write pointer and the lane valid bits
//   (the buffer reads as zero), and loads the register defaults.
//   Configuration is written through cfg_we/cfg_addr/cfg_data while idle.
// ----------------------------------------------------------------------------
module video_line_scan_framebuffer #(
  parameter int ROWS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [vlsf_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  vlsf_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output vlsf_pkg::out_t             out_data
);
  import vlsf_pkg::*;

  localparam logic [PTR_W:0]     BYTES    = (PTR_W + 1)'(ROWS * LANES);
  localparam logic [ROW_IDX_W-1:0] ROWS_IDX = ROW_IDX_W'(ROWS);

  // Configuration registers.
  logic [7:0]        blank_lines;
  logic [LINE_W-1:0] frame_lines;
  logic [REP_W-1:0]  line_repeat;

  // Timing state.
  logic [LINE_W-1:0]    line_count, line_count_next;
  logic [ROW_IDX_W-1:0] row_index, row_index_next;
  logic [REP_W-1:0]     repeat_count, repeat_count_next;
  logic                 sync_is_long, sync_is_long_next;
  logic [PTR_W-1:0]     write_pointer, write_pointer_next;

  // Read stage.
  logic p1_valid, p1_sync, p1_active, p1_done;
  logic active_next, done_next;

  logic accept, tick, p1_go;
  logic [PTR_W-1:0] wr_idx;
  logic [PTR_W:0]   wr_inc;
  logic [REP_W-1:0] rep_inc;
  logic [LINE_W-1:0] line_inc;
  fb_wr_t fb_wr;
  fb_rd_t fb_rd;
  logic [ROW_BITS-1:0] fb_word;

  // Handshake: stall only when both the read stage and the output are held.
  assign p1_go    = p1_valid && (!out_valid || !out_stall);
  assign in_stall = p1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign tick     = accept && (in_data.command == CMD_TICK);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      blank_lines <= BLANK_RESET;
      frame_lines <= FRAME_RESET;
      line_repeat <= REPEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BLANK_LINES: blank_lines <= cfg_data[7:0];
        REG_FRAME_LINES: frame_lines <= cfg_data;
        REG_LINE_REPEAT: line_repeat <= cfg_data[REP_W-1:0];
        default: ;
      endcase
    end
  end

  // Write pointer and byte write request.
  always_comb begin
    wr_idx = (PTR_W + 1)'(write_pointer) >= BYTES ? '0 : write_pointer;
    wr_inc = (PTR_W + 1)'(wr_idx) + 1'b1;
    fb_wr.en   = 1'b0;
    fb_wr.word = wr_idx[FB_ADDR_W+1:2];
    fb_wr.lane = wr_idx[1:0];
    fb_wr.data = in_data.data_byte;
    write_pointer_next = write_pointer;
    if (accept) begin
      case (in_data.command)
        CMD_BYTE: begin
          fb_wr.en = 1'b1;
          write_pointer_next = (wr_inc >= BYTES) ? '0 : wr_inc[PTR_W-1:0];
        end
        CMD_REWIND: write_pointer_next = '0;
        default: ;
      endcase
    end
  end

  // Line timing for a tick, from the state before the tick.
  always_comb begin
    line_inc          = line_count + 1'b1;
    rep_inc           = repeat_count + 1'b1;
    line_count_next   = line_inc;
    row_index_next    = row_index;
    repeat_count_next = repeat_count;
    sync_is_long_next = sync_is_long;
    active_next       = 1'b0;
    done_next         = 1'b0;
    if (line_inc <= {1'b0, blank_lines}) begin
      if (line_inc == SYNC_LONG_LINE) begin
        sync_is_long_next = 1'b1;
        row_index_next    = '0;
      end else if (line_inc == SYNC_SHORT_LINE) begin
        sync_is_long_next = 1'b0;
      end
    end else if (row_index >= ROWS_IDX) begin
      if (line_inc >= frame_lines) begin
        line_count_next = '0;
        done_next       = 1'b1;
      end
    end else begin
      active_next       = 1'b1;
      repeat_count_next = rep_inc;
      if (rep_inc >= line_repeat) begin
        row_index_next    = row_index + 1'b1;
        repeat_count_next = '0;
      end
    end
  end

  // The row shown by a tick is the current row before it advances.
  assign fb_rd.en   = tick;
  assign fb_rd.word = row_index[FB_ADDR_W-1:0];

  vlsf_fbuf #(
    .ROWS(ROWS)
  ) u_fbuf (
    .clk    (clk),
    .rst    (rst),
    .wr     (fb_wr),
    .rd     (fb_rd),
    .rd_word(fb_word)
  );

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count    <= '0;
      row_index     <= '0;
      repeat_count  <= '0;
      sync_is_long  <= 1'b0;
      write_pointer <= '0;
    end else begin
      write_pointer <= write_pointer_next;
      if (tick) begin
        line_count   <= line_count_next;
        row_index    <= row_index_next;
        repeat_count <= repeat_count_next;
        sync_is_long <= sync_is_long_next;
      end
    end
  end

  // Read stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (tick) begin
      p1_valid <= 1'b1;
    end else if (p1_go) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      p1_sync   <= sync_is_long_next;
      p1_active <= active_next;
      p1_done   <= done_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_go) begin
      out_data.long_sync   <= p1_sync;
      out_data.active_line <= p1_active;
      out_data.pixels      <= p1_active ? fb_word : '0;
      out_data.frame_done  <= p1_done;
    end
  end

  // Checks on the timing state and results.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (PTR_W + 1)'(write_pointer) < BYTES)
    else $error("write pointer past the end of the buffer");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_index <= ROWS_IDX)
    else $error("row index past the last row");

  a_done_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> !out_data.active_line)
    else $error("frame end on a picture line");

  a_blank_pixels: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.active_line |-> out_data.pixels == '0)
    else $error("pixels on a blank line");

endmodule

@@ rtl/vlsf_fbuf.sv @@
// ----------------------------------------------------------------------------
// vlsf_fbuf: frame buffer memory with byte lanes
// Byte-wide writes into 32-bit rows and a registered row read. Each byte lane
// keeps a valid bit that reset clears, so an unwritten lane reads as zero.
// ----------------------------------------------------------------------------
module vlsf_fbuf #(
  parameter int ROWS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vlsf_pkg::fb_wr_t              wr,
  input  vlsf_pkg::fb_rd_t              rd,
  output logic [vlsf_pkg::ROW_BITS-1:0] rd_word
);
  import vlsf_pkg::*;

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [LANES-1:0][7:0] mem [ROWS];
  logic [LANES-1:0]      lane_vld [ROWS];
  logic [LANES-1:0][7:0] rd_q;
  logic [LANES-1:0]      rd_vld;

  // Byte lane write and registered row read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.word[AW-1:0]][wr.lane] <= wr.data;
    end
    if (rd.en) begin
      rd_q <= mem[rd.word[AW-1:0]];
    end
  end

  // Lane valid bits, cleared at reset; the read captures them with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        lane_vld[i] <= '0;
      end
      rd_vld <= '0;
    end else begin
      if (wr.en) begin
        lane_vld[wr.word[AW-1:0]][wr.lane] <= 1'b1;
      end
      if (rd.en) begin
        rd_vld <= lane_vld[rd.word[AW-1:0]];
      end
    end
  end

  // Lanes never written read as zero.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rd_word[l*8 +: 8] = rd_q[l] & {8{rd_vld[l]}};
    end
  end

endmodule
